// ===== src/tip_pkg.sv =====
package tip_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_FEW   = 2'd1,
    ST_OUT_RANGE = 2'd2,
    ST_EQUAL_X   = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic {
    REG_POINTS = 1'b0,
    REG_DEGREE = 1'b1
  } cfg_reg_t;

  localparam logic [6:0] POINTS_RESET = 7'd64;
  localparam logic [2:0] DEGREE_RESET = 3'd2;

  // weight and term saturation limits
  localparam logic [62:0] WEIGHT_CAP = 63'(1) << 62;
  localparam logic [58:0] TERM_CAP   = 59'(1) << 58;

endpackage

// ===== src/table_interpolate_1d_top.sv =====
// channel   | handshake               | payload
// ----------+-------------------------+----------------------------------------------
// input     | start, busy             | in_kind, in_point_index, in_point_x,
//           |                         | in_point_y, in_query_x
// result    | out_valid (one cycle)   | out_value, out_status
// config    | cfg_we                  | cfg_index, cfg_data
//
// a load item is taken while idle and writes the point ram; busy stays low
// a query item walks a sequencer over one ram read port: the 4 end reads and the
// end test, then binary search probes, a clamp step, then per window point a read,
// a skip of its own index, the term steps and deg weight factors (read, operands,
// 3 multiply, setup, a bit-serial divide of 64 quotient bits, finish); a factor
// that saturates skips the divide; busy stays high until the result is given
// rst_n is synchronous; it resets the sequencer, out_valid and the config registers,
// the point ram holds no reset value; the receiver cannot stall results
module table_interpolate_1d_top
  import tip_pkg::*;
#(
  parameter int POINTS     = 64,
  parameter int MAX_DEGREE = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [5:0]         in_point_index,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_query_x,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int AW = $clog2(POINTS);
  localparam int NW = $clog2(POINTS + 1);
  localparam int CW = (NW > 7) ? NW : 7;
  localparam int IW = NW + 1;
  localparam int DW = $clog2(MAX_DEGREE + 2);
  localparam int GW = (DW > 3) ? DW : 3;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_CAP, S_NEAR, S_BS, S_BSW, S_CLAMP,
    S_RI, S_RIW, S_RJ, S_RJW, S_MUL0, S_MUL1, S_MUL2, S_WDIV0, S_WDIV, S_WFIN,
    S_TERM, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [6:0] points_r;
  logic [2:0] degree_r;

  // working registers
  logic signed [31:0] qx_r, x0_r, x1_r, xn2_r, xn1_r, xi_r, yi_r;
  logic signed [IW-1:0] lo_r, hi_r, mid_r, ix_r;
  logic               rising_r;
  logic [DW-1:0]      i_r, j_r;
  logic [62:0]        w_r;
  logic               neg_r;
  logic [31:0]        mb_r, den_r, rem_r;
  logic [63:0]        pp_r, q_r;
  logic [95:0]        prod_r;
  logic               term_r;
  logic [5:0]         cnt_r;
  logic signed [63:0] sum_r;
  status_t            status_r;

  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  status_t            out_status_r;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_rdata;
  logic signed [31:0] rx, ry;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] a;
    a = (v < 0) ? -v : v;
    return a[31:0];
  endfunction

  function automatic logic [38:0] times100(input logic [31:0] d);
    return {1'b0, d, 6'b0} + {2'b0, d, 5'b0} + {5'b0, d, 2'b0};
  endfunction

  // effective point count and degree
  logic [CW-1:0] piu_ext, pts_ext;
  logic [GW-1:0] dg_ext;
  logic [NW-1:0] n_c;
  logic [DW-1:0] deg_c;
  logic signed [IW-1:0] n_s, deg_s;

  assign piu_ext = CW'(points_r);
  assign pts_ext = CW'(POINTS);
  assign n_c     = NW'((piu_ext > pts_ext) ? pts_ext : piu_ext);
  assign dg_ext  = GW'(degree_r);
  assign deg_c   = DW'((dg_ext == '0) ? GW'(1) :
                       ((dg_ext > GW'(MAX_DEGREE)) ? GW'(MAX_DEGREE) : dg_ext));
  assign n_s     = IW'(n_c);
  assign deg_s   = IW'(deg_c);

  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start & ~busy;

  assign ram_we    = accept & ~in_kind & (32'(in_point_index) < 32'(POINTS));
  assign ram_waddr = AW'(in_point_index);
  assign rx        = ram_rdata[63:32];
  assign ry        = ram_rdata[31:0];

  tip_ram #(.WIDTH(64), .DEPTH(POINTS)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data ({in_point_x, in_point_y}),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // binary search midpoint and span
  logic signed [IW:0] mid_sum;
  logic signed [IW-1:0] mid_c;
  logic               span_c;
  assign mid_sum = (IW+1)'(lo_r) + (IW+1)'(hi_r);
  assign mid_c   = IW'(mid_sum >>> 1);
  assign span_c  = ((hi_r - lo_r) > IW'(1));

  // read address per state
  always_comb begin
    case (state_r)
      S_RD0:   ram_raddr = '0;
      S_RD1:   ram_raddr = AW'(1);
      S_RD2:   ram_raddr = AW'(n_c - NW'(2));
      S_RD3:   ram_raddr = AW'(n_c - NW'(1));
      S_BS:    ram_raddr = AW'($unsigned(mid_c));
      S_RI:    ram_raddr = AW'($unsigned(ix_r) + IW'(i_r));
      S_RJ:    ram_raddr = AW'($unsigned(ix_r) + IW'(j_r));
      default: ram_raddr = '0;
    endcase
  end

  // tolerance test at the two ends
  logic [31:0] d0, b0, d1, b1;
  logic        near0, near1;
  assign d0    = mag33(33'(qx_r) - 33'(x0_r));
  assign b0    = mag33(33'(x1_r) - 33'(x0_r));
  assign d1    = mag33(33'(qx_r) - 33'(xn1_r));
  assign b1    = mag33(33'(xn2_r) - 33'(xn1_r));
  assign near0 = times100(d0) < 39'(b0);
  assign near1 = times100(d1) < 39'(b1);

  // factor operands
  logic signed [32:0] num_c, den_c;
  assign num_c = 33'(qx_r) - 33'(rx);
  assign den_c = 33'(xi_r) - 33'(rx);

  // one divide step
  logic [32:0] sh_c;
  logic        ge_c;
  assign sh_c = {rem_r, prod_r[63]};
  assign ge_c = (sh_c >= {1'b0, den_r});

  // term and output saturation
  logic [63:0] tq_c;
  logic [58:0] t_c;
  assign tq_c = prod_r[95:32];
  assign t_c  = (tq_c > 64'(TERM_CAP)) ? TERM_CAP : tq_c[58:0];

  logic signed [31:0] sat_c;
  always_comb begin
    if (sum_r > 64'sh7FFF_FFFF) begin
      sat_c = 32'sh7FFF_FFFF;
    end else if (sum_r < -64'sh8000_0000) begin
      sat_c = 32'sh8000_0000;
    end else begin
      sat_c = sum_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      points_r    <= POINTS_RESET;
      degree_r    <= DEGREE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_POINTS: points_r <= cfg_data;
          REG_DEGREE: degree_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_kind) begin
            qx_r     <= in_query_x;
            sum_r    <= '0;
            status_r <= ST_OK;
            if (32'(n_c) <= 32'(deg_c)) begin
              status_r <= ST_TOO_FEW;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_RD0;
            end
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          x0_r    <= rx;
          state_r <= S_RD2;
        end
        S_RD2: begin
          x1_r    <= rx;
          state_r <= S_RD3;
        end
        S_RD3: begin
          xn2_r   <= rx;
          state_r <= S_CAP;
        end
        S_CAP: begin
          xn1_r   <= rx;
          state_r <= S_NEAR;
        end
        S_NEAR: begin
          if (near0) begin
            ix_r    <= '0;
            state_r <= S_CLAMP;
          end else if (near1) begin
            ix_r    <= n_s - IW'(2);
            state_r <= S_CLAMP;
          end else begin
            lo_r     <= -IW'(1);
            hi_r     <= n_s;
            rising_r <= (xn1_r > x0_r);
            state_r  <= S_BS;
          end
        end
        S_BS: begin
          if (span_c) begin
            mid_r   <= mid_c;
            state_r <= S_BSW;
          end else begin
            ix_r    <= lo_r;
            state_r <= S_CLAMP;
          end
        end
        S_BSW: begin
          if ((qx_r > rx) == rising_r) begin
            lo_r <= mid_r;
          end else begin
            hi_r <= mid_r;
          end
          state_r <= S_BS;
        end
        S_CLAMP: begin
          if ((ix_r < 0) || (ix_r >= n_s - IW'(1))) begin
            status_r <= ST_OUT_RANGE;
            state_r  <= S_OUT;
          end else begin
            if (ix_r >= n_s - deg_s) begin
              ix_r <= n_s - deg_s - IW'(1);
            end
            i_r     <= '0;
            state_r <= S_RI;
          end
        end
        S_RI: state_r <= S_RIW;
        S_RIW: begin
          xi_r    <= rx;
          yi_r    <= ry;
          w_r     <= 63'(1) << 32;
          neg_r   <= (ry < 0);
          j_r     <= '0;
          state_r <= S_RJ;
        end
        S_RJ: begin
          if (j_r > deg_c) begin
            mb_r    <= mag33(33'(yi_r));
            term_r  <= 1'b1;
            state_r <= S_MUL0;
          end else if (j_r == i_r) begin
            j_r <= j_r + DW'(1);
          end else begin
            state_r <= S_RJW;
          end
        end
        S_RJW: begin
          if (den_c == '0) begin
            status_r <= ST_EQUAL_X;
            sum_r    <= '0;
            state_r  <= S_OUT;
          end else begin
            neg_r   <= neg_r ^ ((num_c < 0) != (den_c < 0));
            mb_r    <= mag33(num_c);
            den_r   <= mag33(den_c);
            term_r  <= 1'b0;
            state_r <= S_MUL0;
          end
        end
        S_MUL0: begin
          pp_r    <= 64'(w_r[31:0]) * 64'(mb_r);
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          prod_r  <= 96'(pp_r);
          pp_r    <= 64'(w_r[62:32]) * 64'(mb_r);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= prod_r + {pp_r, 32'b0};
          state_r <= term_r ? S_TERM : S_WDIV0;
        end
        S_WDIV0: begin
          if (prod_r[95:64] >= den_r) begin
            w_r     <= WEIGHT_CAP;
            j_r     <= j_r + DW'(1);
            state_r <= S_RJ;
          end else begin
            rem_r   <= prod_r[95:64];
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_WDIV;
          end
        end
        S_WDIV: begin
          rem_r         <= ge_c ? 32'(sh_c - {1'b0, den_r}) : sh_c[31:0];
          prod_r[63:0]  <= {prod_r[62:0], 1'b0};
          q_r           <= {q_r[62:0], ge_c};
          cnt_r         <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            state_r <= S_WFIN;
          end
        end
        S_WFIN: begin
          w_r     <= (q_r > 64'(WEIGHT_CAP)) ? WEIGHT_CAP : q_r[62:0];
          j_r     <= j_r + DW'(1);
          state_r <= S_RJ;
        end
        S_TERM: begin
          sum_r <= neg_r ? (sum_r - $signed(64'(t_c))) : (sum_r + $signed(64'(t_c)));
          if (i_r == deg_c) begin
            state_r <= S_OUT;
          end else begin
            i_r     <= i_r + DW'(1);
            state_r <= S_RI;
          end
        end
        S_OUT: begin
          out_valid_r  <= 1'b1;
          out_value_r  <= (status_r == ST_OK) ? sat_c : '0;
          out_status_r <= status_r;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ===== src/tip_ram.sv =====
module tip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
